// ===== hw/rtl/frt_pkg.sv =====
`default_nettype none

package frt_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned MagBits    = CoordBits;
  localparam int unsigned FracBits   = 8;
  localparam int unsigned SqBits     = 2 * MagBits + 1;
  localparam int unsigned RadBits    = SqBits + 2 * FracBits;
  localparam int unsigned RootBits   = (RadBits + 1) / 2;
  localparam int unsigned RemBits    = RootBits + 3;
  localparam int unsigned SumBits    = 32;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CfgStartX = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgStartY = CfgIdxBits'(1);

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pos_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } in_word_t;

  typedef struct packed {
    coord_t route_x;
    coord_t route_y;
    logic   route_last;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  typedef struct packed {
    logic   start;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } dist_req_t;

  typedef struct packed {
    logic                done;
    logic [RootBits-1:0] root;
  } dist_rsp_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SQX,
    D_SQY,
    D_ROOT
  } dist_state_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FIRST_GO,
    S_FIRST_WT,
    S_SEL_GO,
    S_SEL_WT,
    S_INS_GO,
    S_INS_WT,
    S_INS_DO,
    S_EMIT
  } seq_state_e;

  function automatic logic [SumBits-1:0] sat_add(input logic [SumBits-1:0] a,
                                                 input logic [SumBits-1:0] b);
    logic [SumBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumBits] ? {SumBits{1'b1}} : s[SumBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frt_dist.sv =====
`default_nettype none

module frt_dist (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire frt_pkg::dist_req_t req_i,
  output frt_pkg::dist_rsp_t     rsp_o
);

  localparam int unsigned StepBits = $clog2(frt_pkg::RootBits);

  frt_pkg::dist_state_e state_q, state_d;
  logic [frt_pkg::MagBits-1:0]    mx_q, mx_d, my_q, my_d;
  logic [frt_pkg::SqBits-1:0]     sq_q, sq_d;
  logic [2*frt_pkg::RootBits-1:0] rad_q, rad_d;
  logic [frt_pkg::RemBits-1:0]    rem_q, rem_d;
  logic [frt_pkg::RootBits-1:0]   root_q, root_d;
  logic [StepBits-1:0]            step_q, step_d;
  logic                           done_q, done_d;

  logic signed [frt_pkg::CoordBits:0] dx, dy;
  logic [frt_pkg::SqBits-1:0]         sq_sum;
  logic [frt_pkg::RemBits-1:0]        rem2, trial;

  always_comb begin
    dx = {req_i.ax[frt_pkg::CoordBits-1], req_i.ax} - {req_i.bx[frt_pkg::CoordBits-1], req_i.bx};
    dy = {req_i.ay[frt_pkg::CoordBits-1], req_i.ay} - {req_i.by[frt_pkg::CoordBits-1], req_i.by};
    sq_sum = sq_q + frt_pkg::SqBits'(my_q) * frt_pkg::SqBits'(my_q);
    rem2  = {rem_q[frt_pkg::RemBits-3:0], rad_q[2*frt_pkg::RootBits-1 -: 2]};
    trial = frt_pkg::RemBits'({root_q, 2'b01});

    state_d = state_q;
    mx_d    = mx_q;
    my_d    = my_q;
    sq_d    = sq_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    done_d  = 1'b0;

    unique case (state_q)
      frt_pkg::D_IDLE: begin
        if (req_i.start) begin
          mx_d    = dx[frt_pkg::CoordBits] ? frt_pkg::MagBits'(-dx) : frt_pkg::MagBits'(dx);
          my_d    = dy[frt_pkg::CoordBits] ? frt_pkg::MagBits'(-dy) : frt_pkg::MagBits'(dy);
          state_d = frt_pkg::D_SQX;
        end
      end
      frt_pkg::D_SQX: begin
        sq_d    = frt_pkg::SqBits'(mx_q) * frt_pkg::SqBits'(mx_q);
        state_d = frt_pkg::D_SQY;
      end
      frt_pkg::D_SQY: begin
        // radicand carries 16 fraction bits so the root carries 8
        rad_d   = (2*frt_pkg::RootBits)'(sq_sum) << (2 * frt_pkg::FracBits);
        rem_d   = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = frt_pkg::D_ROOT;
      end
      frt_pkg::D_ROOT: begin
        if (rem2 >= trial) begin
          rem_d  = rem2 - trial;
          root_d = {root_q[frt_pkg::RootBits-2:0], 1'b1};
        end else begin
          rem_d  = rem2;
          root_d = {root_q[frt_pkg::RootBits-2:0], 1'b0};
        end
        rad_d  = rad_q << 2;
        step_d = step_q + StepBits'(1);
        if (step_q == StepBits'(frt_pkg::RootBits - 1)) begin
          done_d  = 1'b1;
          state_d = frt_pkg::D_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frt_pkg::D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    my_q   <= my_d;
    sq_q   <= sq_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

// ===== hw/rtl/frt_seq.sv =====
`default_nettype none

module frt_seq #(
  parameter int unsigned MAX_POINTS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire frt_pkg::pos_t      start_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire frt_pkg::in_word_t  in_word_i,
  output frt_pkg::emit_t          emit_o,
  input  wire logic               emit_take_i,
  output frt_pkg::dist_req_t      dist_req_o,
  input  wire frt_pkg::dist_rsp_t dist_rsp_i
);

  localparam int unsigned IdxBits = $clog2(MAX_POINTS);
  localparam int unsigned CntBits = $clog2(MAX_POINTS + 1);

  frt_pkg::seq_state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d, n_q, n_d, len_q, len_d;
  logic [CntBits-1:0] i_q, i_d, k_q, k_d, src_q, src_d, e_q, e_d, pos_q, pos_d;
  logic [IdxBits-1:0] best_q, best_d;
  logic               found_q, found_d, closing_q, closing_d;
  logic [MAX_POINTS-1:0] visited_q, visited_d;
  logic [frt_pkg::SumBits-1:0] bestv_q, bestv_d, acc_q, acc_d, short_q, short_d;
  frt_pkg::pos_t pj_q, pj_d, prv_q, prv_d;

  frt_pkg::pos_t      store_q [MAX_POINTS];
  logic [IdxBits-1:0] ro_q    [MAX_POINTS];

  logic [IdxBits-1:0] ro_addr, rd_addr, ro_rd, ins_idx;
  logic [CntBits-1:0] ins_kn, e_m1;
  logic               ins_hit, st_we, ro_first_we, ro_ins_we;
  frt_pkg::pos_t      rd_pt;
  logic [frt_pkg::SumBits-1:0] d, s;

  assign ro_rd = ro_q[ro_addr];
  assign rd_pt = store_q[rd_addr];
  assign d     = frt_pkg::SumBits'(dist_rsp_i.root);
  assign s     = frt_pkg::sat_add(acc_q, d);

  always_comb begin
    e_m1    = e_q - CntBits'(1);
    ins_kn  = (state_q == frt_pkg::S_INS_GO) ? '0 : k_q + CntBits'(1);
    ins_hit = (ins_kn == i_q);
    unique case (state_q)
      frt_pkg::S_SEL_WT:                    ro_addr = k_q[IdxBits-1:0];
      frt_pkg::S_INS_GO, frt_pkg::S_INS_WT: ro_addr = src_q[IdxBits-1:0];
      frt_pkg::S_EMIT:                      ro_addr = e_m1[IdxBits-1:0];
      default:                              ro_addr = '0;
    endcase
    ins_idx = ins_hit ? best_q : ro_rd;
    unique case (state_q)
      frt_pkg::S_FIRST_GO, frt_pkg::S_SEL_GO: rd_addr = i_q[IdxBits-1:0];
      frt_pkg::S_SEL_WT, frt_pkg::S_EMIT:     rd_addr = ro_rd;
      frt_pkg::S_INS_GO, frt_pkg::S_INS_WT:   rd_addr = ins_idx;
      default:                                rd_addr = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;   cnt_d = cnt_q;     n_d = n_q;         len_d = len_q;
    i_d = i_q;           k_d = k_q;         src_d = src_q;     e_d = e_q;
    pos_d = pos_q;       best_d = best_q;   found_d = found_q; closing_d = closing_q;
    visited_d = visited_q;
    bestv_d = bestv_q;   acc_d = acc_q;     short_d = short_q;
    pj_d = pj_q;         prv_d = prv_q;
    in_ready_o = 1'b0;   st_we = 1'b0;      ro_first_we = 1'b0; ro_ins_we = 1'b0;
    dist_req_o = '0;
    emit_o     = '0;

    unique case (state_q)
      frt_pkg::S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // a point beyond a full set is dropped
          if (cnt_q < CntBits'(MAX_POINTS)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CntBits'(1);
          end
          if (in_word_i.last_point) begin
            n_d     = cnt_d;
            i_d     = '0;
            state_d = frt_pkg::S_FIRST_GO;
          end
        end
      end
      frt_pkg::S_FIRST_GO: begin
        dist_req_o = '{start: 1'b1, ax: start_i.x, ay: start_i.y, bx: rd_pt.x, by: rd_pt.y};
        state_d    = frt_pkg::S_FIRST_WT;
      end
      frt_pkg::S_FIRST_WT: begin
        if (dist_rsp_i.done) begin
          // later index wins on a tie
          if (i_q == '0 || d >= bestv_q) begin
            bestv_d = d;
            best_d  = i_q[IdxBits-1:0];
          end
          if (i_q + CntBits'(1) == n_q) begin
            ro_first_we = 1'b1;
            len_d       = CntBits'(1);
            visited_d   = MAX_POINTS'(1) << best_d;
            e_d         = '0;
            i_d         = '0;
            found_d     = 1'b0;
            state_d     = (n_q == CntBits'(1)) ? frt_pkg::S_EMIT : frt_pkg::S_SEL_GO;
          end else begin
            i_d     = i_q + CntBits'(1);
            state_d = frt_pkg::S_FIRST_GO;
          end
        end
      end
      frt_pkg::S_SEL_GO: begin
        priority if (i_q == n_q) begin
          i_d     = '0;
          src_d   = '0;
          state_d = frt_pkg::S_INS_GO;
        end else if (visited_q[i_q[IdxBits-1:0]]) begin
          i_d = i_q + CntBits'(1);
        end else begin
          dist_req_o = '{start: 1'b1, ax: start_i.x, ay: start_i.y, bx: rd_pt.x, by: rd_pt.y};
          pj_d    = rd_pt;
          k_d     = '0;
          acc_d   = '0;
          state_d = frt_pkg::S_SEL_WT;
        end
      end
      frt_pkg::S_SEL_WT: begin
        if (dist_rsp_i.done) begin
          acc_d = s;
          if (k_q == len_q) begin
            if (!found_q || s > bestv_q) begin
              found_d = 1'b1;
              bestv_d = s;
              best_d  = i_q[IdxBits-1:0];
            end
            i_d     = i_q + CntBits'(1);
            state_d = frt_pkg::S_SEL_GO;
          end else begin
            dist_req_o = '{start: 1'b1, ax: rd_pt.x, ay: rd_pt.y, bx: pj_q.x, by: pj_q.y};
            k_d = k_q + CntBits'(1);
          end
        end
      end
      frt_pkg::S_INS_GO: begin
        if (i_q > len_q) begin
          state_d = frt_pkg::S_INS_DO;
        end else begin
          dist_req_o = '{start: 1'b1, ax: start_i.x, ay: start_i.y, bx: rd_pt.x, by: rd_pt.y};
          prv_d     = rd_pt;
          k_d       = '0;
          acc_d     = '0;
          closing_d = 1'b0;
          src_d     = ins_hit ? src_q : src_q + CntBits'(1);
          state_d   = frt_pkg::S_INS_WT;
        end
      end
      frt_pkg::S_INS_WT: begin
        if (dist_rsp_i.done) begin
          acc_d = s;
          priority if (closing_q) begin
            // earliest position wins on a tie
            if (i_q == '0 || s < short_q) begin
              short_d = s;
              pos_d   = i_q;
            end
            i_d     = i_q + CntBits'(1);
            src_d   = '0;
            state_d = frt_pkg::S_INS_GO;
          end else if (k_q == len_q) begin
            // return leg to the start
            dist_req_o = '{start: 1'b1, ax: prv_q.x, ay: prv_q.y, bx: start_i.x, by: start_i.y};
            closing_d  = 1'b1;
          end else begin
            dist_req_o = '{start: 1'b1, ax: prv_q.x, ay: prv_q.y, bx: rd_pt.x, by: rd_pt.y};
            prv_d = rd_pt;
            k_d   = ins_kn;
            src_d = ins_hit ? src_q : src_q + CntBits'(1);
          end
        end
      end
      frt_pkg::S_INS_DO: begin
        ro_ins_we = 1'b1;
        len_d     = len_q + CntBits'(1);
        visited_d = visited_q | (MAX_POINTS'(1) << best_q);
        i_d       = '0;
        found_d   = 1'b0;
        e_d       = '0;
        state_d   = (len_q + CntBits'(1) == n_q) ? frt_pkg::S_EMIT : frt_pkg::S_SEL_GO;
      end
      frt_pkg::S_EMIT: begin
        emit_o.valid = 1'b1;
        if (e_q == '0) begin
          emit_o.word = '{route_x: start_i.x, route_y: start_i.y, route_last: 1'b0};
        end else begin
          emit_o.word = '{route_x: rd_pt.x, route_y: rd_pt.y, route_last: (e_q == n_q)};
        end
        if (emit_take_i) begin
          e_d = e_q + CntBits'(1);
          if (e_q == n_q) begin
            cnt_d   = '0;
            state_d = frt_pkg::S_LOAD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= frt_pkg::S_LOAD;
      cnt_q     <= '0;
      n_q       <= '0;
      len_q     <= '0;
      i_q       <= '0;
      k_q       <= '0;
      src_q     <= '0;
      e_q       <= '0;
      pos_q     <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      closing_q <= 1'b0;
      visited_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      len_q     <= len_d;
      i_q       <= i_d;
      k_q       <= k_d;
      src_q     <= src_d;
      e_q       <= e_d;
      pos_q     <= pos_d;
      best_q    <= best_d;
      found_q   <= found_d;
      closing_q <= closing_d;
      visited_q <= visited_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bestv_q <= bestv_d;
    acc_q   <= acc_d;
    short_q <= short_d;
    pj_q    <= pj_d;
    prv_q   <= prv_d;
    if (st_we) begin
      store_q[cnt_q[IdxBits-1:0]] <= '{x: in_word_i.point_x, y: in_word_i.point_y};
    end
  end

  // tour order: each entry takes its lower neighbour when a point is inserted ahead of it
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_ro
    always_ff @(posedge clk_i) begin
      if (ro_first_we && g == 0) begin
        ro_q[g] <= best_d;
      end else if (ro_ins_we) begin
        if (CntBits'(g) == pos_q) begin
          ro_q[g] <= best_q;
        end else if (g > 0 && CntBits'(g) > pos_q && CntBits'(g) <= len_q) begin
          ro_q[g] <= ro_q[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/farthest_insertion_route.sv =====
// channel  direction  handshake                    word
// in       input      in_valid_i / in_ready_o      frt_pkg::in_word_t  (one target point)
// out      output     out_valid_o / out_ready_i    frt_pkg::out_word_t (one route stop)
// cfg      input      cfg_we_i, cfg_idx_i          cfg_data_i          (start_x, start_y)
//
// each handshake takes one point; the word with last_point starts planning and
// in_ready_o stays low until the last stop has entered the output register.
// planning runs on one shared distance unit (abs diff, two squares, one root bit
// a cycle), on the order of n^3/2 distances for n points.
// reset clears control state and the start position; stored points need no clearing.
// a stalled output holds its word in the output register; the next set may load meanwhile.
`default_nettype none

module farthest_insertion_route #(
  parameter int unsigned MAX_POINTS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire frt_pkg::in_word_t                  in_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output frt_pkg::out_word_t                      out_word_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [frt_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [frt_pkg::CoordBits-1:0]      cfg_data_i
);

  frt_pkg::pos_t      start_q;
  frt_pkg::emit_t     emit;
  frt_pkg::dist_req_t dist_req;
  frt_pkg::dist_rsp_t dist_rsp;
  frt_pkg::out_word_t out_q;
  logic               ov_q, ov_d, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == frt_pkg::CfgStartX) start_q.x <= cfg_data_i;
      if (cfg_idx_i == frt_pkg::CfgStartY) start_q.y <= cfg_data_i;
    end
  end

  assign take = emit.valid && (!ov_q || out_ready_i);

  always_comb begin
    priority if (take)   ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
    else                 ov_d = ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else         ov_q <= ov_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= emit.word;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = out_q;

  frt_seq #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .emit_o     (emit),
    .emit_take_i(take),
    .dist_req_o (dist_req),
    .dist_rsp_i (dist_rsp)
  );

  frt_dist u_dist (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dist_req),
    .rsp_o (dist_rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/frt_checker.sv =====
`default_nettype none

module frt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire frt_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire frt_pkg::out_word_t out_word_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("output word changed while stalled");

  // an ordinary point keeps the block loading
  a_load_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !in_word_i.last_point) |=> in_ready_o)
    else $error("ready dropped after an ordinary point");

  // the closing point starts planning
  a_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.last_point) |=> !in_ready_o)
    else $error("ready stayed high after the closing point");

  // while loading, only the final stop of a route can still be waiting
  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && out_valid_o) |-> out_word_o.route_last)
    else $error("route stop pending while loading");

endmodule

bind farthest_insertion_route frt_checker u_frt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

`default_nettype wire
